@@ rtl/tsfr_pkg.sv @@
package tsfr_pkg;

  localparam int FADE_BITS    = 20;
  localparam int TRACK_BITS   = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int PROD_BITS    = SAMPLE_BITS + FADE_BITS;
  localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS);

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_IN   = 2'd1;
  localparam logic [1:0] MODE_OUT  = 2'd2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PLAY = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          source_valid;
    logic [TRACK_BITS-1:0]         track_id;
    logic                          loop_enable;
    logic [FADE_BITS-1:0]          fade_len;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [TRACK_BITS-1:0]         playing_track;
    logic                          playing_loop;
    logic [1:0]                    fade_mode;
    logic                          track_started;
  } out_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAMPLE_BITS:0] v
  );
    logic signed [SAMPLE_BITS:0] hi;
    logic signed [SAMPLE_BITS:0] lo;
    hi = (SAMPLE_BITS+1)'(2**(SAMPLE_BITS-1) - 1);
    lo = -(SAMPLE_BITS+1)'(2**(SAMPLE_BITS-1));
    if (v > hi) begin
      sat_sample = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_BITS-1:0];
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

@@ rtl/tsfr_div.sv @@
module tsfr_div
  import tsfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [PROD_BITS-1:0]   dividend,
  input  logic [FADE_BITS-1:0]   divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quotient
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [FADE_BITS-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]  lo_r, lo_nxt;
  logic [FADE_BITS-1:0]    dvs_r, dvs_nxt;
  logic [FADE_BITS:0]      trial;
  logic                    ge;

  assign trial = {rem_r, lo_r[SAMPLE_BITS-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[PROD_BITS-1:SAMPLE_BITS];
      lo_nxt   = dividend[SAMPLE_BITS-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? FADE_BITS'(trial - {1'b0, dvs_r}) : trial[FADE_BITS-1:0];
      lo_nxt  = {lo_r[SAMPLE_BITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_BITS'(SAMPLE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = lo_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("Divider started while busy.");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("Divider done without a preceding step.");
  a_busy_fits: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dvs_r)
    else $error("Divider remainder out of range.");
`endif

endmodule

@@ rtl/track_switch_fade_ramp.sv @@
// Music stream fader. Each transfer on the input channel is either a sample tick
// or a play request, and each one produces exactly one result transfer carrying the
// faded sample and the track state the source must follow next. A play request or
// a tick outside a fade goes straight to the done state, from which its result is
// loaded into the output register. A tick inside a fade multiplies the sample by
// the gain and then runs a 16-step restoring divider that is shared by every fading
// tick, before it reaches the done state. A stalled output register holds the item
// in the done state until the register is free.
// The input channel stalls from the transfer until its result is loaded into the
// output register; a result waiting there does not block the next input transfer.
module track_switch_fade_ramp
  import tsfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]            st_r, st_nxt;
  logic [TRACK_BITS-1:0] ct_r, ct_nxt;
  logic                  cl_r, cl_nxt;
  logic [TRACK_BITS-1:0] pt_r, pt_nxt;
  logic                  pl_r, pl_nxt;
  logic                  ps_r, ps_nxt;
  logic [1:0]            fs_r, fs_nxt;
  logic [FADE_BITS-1:0]  ftot_r, ftot_nxt;
  logic [FADE_BITS-1:0]  frem_r, frem_nxt;

  logic                          started_r, started_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic [SAMPLE_BITS-1:0]        mag_r, mag_nxt;
  logic                          neg_r, neg_nxt;
  logic [FADE_BITS-1:0]          g_r, g_nxt;
  logic [PROD_BITS-1:0]          prod_r;
  logic                          out_valid_r;
  out_t                          out_data_r;

  logic                          in_xfer;
  logic                          step_ramp;
  logic [SAMPLE_BITS-1:0]        div_q;
  logic                          div_done;
  logic signed [SAMPLE_BITS:0]   q_signed;

  assign in_stall = (st_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    logic signed [SAMPLE_BITS-1:0] smp;
    ct_nxt      = ct_r;
    cl_nxt      = cl_r;
    pt_nxt      = pt_r;
    pl_nxt      = pl_r;
    ps_nxt      = ps_r;
    fs_nxt      = fs_r;
    ftot_nxt    = ftot_r;
    frem_nxt    = frem_r;
    started_nxt = 1'b0;
    res_nxt     = '0;
    step_ramp   = 1'b0;
    g_nxt       = '0;
    smp         = '0;
    if (in_data.req_type == REQ_PLAY) begin
      if (in_data.track_id != '0 && in_data.track_id == ct_r && !ps_r) begin
        cl_nxt = in_data.loop_enable;
      end else begin
        ftot_nxt = in_data.fade_len;
        pt_nxt   = in_data.track_id;
        pl_nxt   = in_data.loop_enable;
        ps_nxt   = 1'b1;
        if (ct_r != '0 && in_data.fade_len != '0) begin
          fs_nxt   = MODE_OUT;
          frem_nxt = in_data.fade_len;
        end else begin
          ps_nxt = 1'b0;
          if (in_data.track_id != '0) begin
            ct_nxt      = in_data.track_id;
            cl_nxt      = in_data.loop_enable;
            started_nxt = 1'b1;
            if (in_data.fade_len != '0) begin
              fs_nxt   = MODE_IN;
              frem_nxt = in_data.fade_len;
            end else begin
              fs_nxt = MODE_NONE;
            end
          end else begin
            ct_nxt = '0;
            fs_nxt = MODE_NONE;
          end
        end
      end
    end else begin
      if (fs_r == MODE_OUT && frem_r == '0) begin
        if (ps_r && pt_r != '0) begin
          ct_nxt      = pt_r;
          cl_nxt      = pl_r;
          started_nxt = 1'b1;
          if (ftot_r != '0) begin
            fs_nxt   = MODE_IN;
            frem_nxt = ftot_r;
          end else begin
            fs_nxt = MODE_NONE;
          end
        end else begin
          ct_nxt = '0;
          fs_nxt = MODE_NONE;
        end
        ps_nxt = 1'b0;
      end
      if (ct_nxt != '0) begin
        smp = in_data.source_valid ? in_data.sample_in : '0;
        if (!in_data.source_valid && !cl_nxt && fs_nxt != MODE_OUT) begin
          ct_nxt = '0;
        end
        if ((fs_nxt == MODE_IN || fs_nxt == MODE_OUT) && ftot_nxt != '0) begin
          step_ramp = 1'b1;
          if (fs_nxt == MODE_OUT) begin
            g_nxt = (frem_nxt > ftot_nxt) ? ftot_nxt : frem_nxt;
          end else begin
            g_nxt = (frem_nxt > ftot_nxt) ? '0 : ftot_nxt - frem_nxt;
          end
          if (frem_nxt != '0) begin
            frem_nxt = frem_nxt - 1'b1;
          end
          if (fs_nxt == MODE_IN && frem_nxt == '0) begin
            fs_nxt = MODE_NONE;
          end
        end
        res_nxt = smp;
      end
    end
    neg_nxt = smp[SAMPLE_BITS-1];
    mag_nxt = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp) : SAMPLE_BITS'(smp);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          st_nxt = step_ramp ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  st_nxt = ST_LOAD;
      ST_LOAD: st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign q_signed = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  tsfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (st_r == ST_LOAD),
    .dividend (prod_r),
    .divisor  (ftot_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ct_r        <= '0;
      cl_r        <= 1'b0;
      pt_r        <= '0;
      pl_r        <= 1'b0;
      ps_r        <= 1'b0;
      fs_r        <= MODE_NONE;
      ftot_r      <= '0;
      frem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_xfer) begin
        ct_r   <= ct_nxt;
        cl_r   <= cl_nxt;
        pt_r   <= pt_nxt;
        pl_r   <= pl_nxt;
        ps_r   <= ps_nxt;
        fs_r   <= fs_nxt;
        ftot_r <= ftot_nxt;
        frem_r <= frem_nxt;
      end
      if (st_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      started_r <= started_nxt;
      res_r     <= res_nxt;
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      g_r       <= g_nxt;
    end
    if (st_r == ST_MUL) begin
      prod_r <= PROD_BITS'(mag_r * g_r);
    end
    if (st_r == ST_DIV && div_done) begin
      res_r <= sat_sample(q_signed);
    end
    if (st_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.sample_out    <= res_r;
      out_data_r.playing_track <= ct_r;
      out_data_r.playing_loop  <= cl_r;
      out_data_r.fade_mode     <= fs_r;
      out_data_r.track_started <= started_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> st_r != ST_IDLE)
    else $error("Input transfer did not start processing.");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_DONE)
    else $error("Result presented without a finished item.");
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == ST_DIV)
    else $error("Divider finished outside the divide state.");
  a_ramp_total: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LOAD |-> ftot_r != '0)
    else $error("Divide started with zero fade total.");
`endif

endmodule

@@ test/track_switch_fade_ramp_scoreboard.sv @@
module track_switch_fade_ramp_scoreboard
  import tsfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   mismatches,
  output int   outstanding
);

  logic [TRACK_BITS-1:0] cur_trk;
  logic                  cur_loop;
  logic [TRACK_BITS-1:0] next_trk;
  logic                  next_loop;
  logic                  next_queued;
  logic [1:0]            mode;
  logic [FADE_BITS-1:0]  ramp_len;
  logic [FADE_BITS-1:0]  ramp_left;

  out_t fader_out_q[$];
  out_t want;
  out_t got;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic start_track(input logic [TRACK_BITS-1:0] trk, input logic lp);
    cur_trk = trk;
    cur_loop = lp;
    if (ramp_len != 0) begin
      mode = MODE_IN;
      ramp_left = ramp_len;
    end else begin
      mode = MODE_NONE;
    end
  endtask

  task automatic fader_step(input in_t item, output out_t res);
    logic signed [31:0] smp;
    longint gain;
    longint scaled;
    logic started;
    started = 1'b0;
    smp = 0;
    if (item.req_type == REQ_PLAY) begin
      if (item.track_id != 0 && item.track_id == cur_trk && !next_queued) begin
        cur_loop = item.loop_enable;
      end else begin
        ramp_len = item.fade_len;
        next_trk = item.track_id;
        next_loop = item.loop_enable;
        next_queued = 1'b1;
        if (cur_trk != 0 && item.fade_len != 0) begin
          mode = MODE_OUT;
          ramp_left = item.fade_len;
        end else begin
          next_queued = 1'b0;
          if (item.track_id != 0) begin
            start_track(item.track_id, item.loop_enable);
            started = 1'b1;
          end else begin
            cur_trk = '0;
            mode = MODE_NONE;
          end
        end
      end
    end else begin
      // A finished fade-out hands over to the queued track, if there is one.
      if (mode == MODE_OUT && ramp_left == 0) begin
        if (next_queued && next_trk != 0) begin
          start_track(next_trk, next_loop);
          started = 1'b1;
        end else begin
          cur_trk = '0;
          mode = MODE_NONE;
        end
        next_queued = 1'b0;
      end
      if (cur_trk != 0) begin
        if (item.source_valid) begin
          smp = 32'(item.sample_in);
        end
        if (!item.source_valid && !cur_loop && mode != MODE_OUT) begin
          cur_trk = '0;
        end
        if ((mode == MODE_IN || mode == MODE_OUT) && ramp_len != 0) begin
          if (mode == MODE_OUT) begin
            gain = longint'(ramp_left);
          end else begin
            gain = longint'(ramp_len) - longint'(ramp_left);
          end
          if (gain < 0) begin
            gain = 0;
          end
          if (gain > longint'(ramp_len)) begin
            gain = longint'(ramp_len);
          end
          scaled = (longint'(smp) * gain) / longint'(ramp_len);
          if (scaled > 32767) begin
            scaled = 32767;
          end else if (scaled < -32768) begin
            scaled = -32768;
          end
          smp = scaled[31:0];
          if (ramp_left != 0) begin
            ramp_left = ramp_left - 1'b1;
          end
          if (mode == MODE_IN && ramp_left == 0) begin
            mode = MODE_NONE;
          end
        end
      end
    end
    res.sample_out = smp[SAMPLE_BITS-1:0];
    res.playing_track = cur_trk;
    res.playing_loop = cur_loop;
    res.fade_mode = mode;
    res.track_started = started;
  endtask

  task automatic report_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_trk = '0;
      cur_loop = 1'b0;
      next_trk = '0;
      next_loop = 1'b0;
      next_queued = 1'b0;
      mode = MODE_NONE;
      ramp_len = '0;
      ramp_left = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (fader_out_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none got %h", $time, out_data);
          mismatches++;
        end else begin
          want = fader_out_q.pop_front();
          report_field("sample_out", want.sample_out, out_data.sample_out);
          report_field("playing_track", 16'(want.playing_track), 16'(out_data.playing_track));
          report_field("playing_loop", 16'(want.playing_loop), 16'(out_data.playing_loop));
          report_field("fade_mode", 16'(want.fade_mode), 16'(out_data.fade_mode));
          report_field("track_started", 16'(want.track_started),
                       16'(out_data.track_started));
        end
      end
      if (in_valid && !in_stall) begin
        fader_step(in_data, got);
        fader_out_q.push_back(got);
      end
      outstanding = fader_out_q.size();
    end
  end

endmodule

@@ test/track_switch_fade_ramp_tb.sv @@
module track_switch_fade_ramp_tb;
  import tsfr_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int ITEM_COUNT  = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   mismatches;
  int   outstanding;

  int burst_left = 0;
  int sent = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  track_switch_fade_ramp DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  track_switch_fade_ramp_scoreboard scoreboard (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_t make_play(input logic [TRACK_BITS-1:0] trk, input logic lp,
                                    input logic [FADE_BITS-1:0] flen);
    in_t item;
    item.req_type = REQ_PLAY;
    item.sample_in = SAMPLE_BITS'($urandom);
    item.source_valid = 1'($urandom_range(1, 0));
    item.track_id = trk;
    item.loop_enable = lp;
    item.fade_len = flen;
    return item;
  endfunction

  function automatic in_t make_tick(input logic [SAMPLE_BITS-1:0] smp, input logic ok);
    in_t item;
    item.req_type = REQ_TICK;
    item.sample_in = smp;
    item.source_valid = ok;
    item.track_id = TRACK_BITS'($urandom);
    item.loop_enable = 1'($urandom_range(1, 0));
    item.fade_len = FADE_BITS'($urandom);
    return item;
  endfunction

  function automatic logic [TRACK_BITS-1:0] pick_track();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return TRACK_BITS'($urandom);
      default: return TRACK_BITS'($urandom_range(3, 1));
    endcase
  endfunction

  function automatic logic [FADE_BITS-1:0] pick_len();
    case ($urandom_range(9, 0))
      0, 1: return '0;
      2: return FADE_BITS'($urandom);
      default: return FADE_BITS'($urandom_range(16, 1));
    endcase
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // The receiver stalls in segments of random density; a requested hold-off wins.
  initial begin
    int seg_left;
    int stall_pct;
    seg_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(80, 10);
          case ($urandom_range(3, 0))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("track_switch_fade_ramp regression: fail");
    $finish;
  end

  initial begin
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(make_tick(16'h7fff, 1'b1));
    send_item(make_play(8'd255, 1'b1, 20'd0));
    send_item(make_tick(16'h8000, 1'b1));
    send_item(make_tick(16'h7fff, 1'b1));
    send_item(make_play(8'd255, 1'b0, 20'd5));
    send_item(make_play(8'd1, 1'b0, 20'd3));
    repeat (4) send_item(make_tick(16'h8000, 1'b1));
    send_item(make_tick(16'h7fff, 1'b1));
    send_item(make_tick(16'h8000, 1'b1));
    send_item(make_tick(16'h1234, 1'b0));
    send_item(make_play(8'd2, 1'b1, 20'd2));
    send_item(make_tick(16'h7fff, 1'b0));
    send_item(make_play(8'd0, 1'b0, 20'd2));
    repeat (3) send_item(make_tick(16'hffff, 1'b1));
    send_item(make_play(8'd3, 1'b0, 20'hfffff));
    send_item(make_tick(16'hffff, 1'b1));
    send_item(make_play(8'd4, 1'b0, 20'd0));
    send_item(make_play(8'd5, 1'b1, 20'd2));
    send_item(make_tick(16'h4000, 1'b0));
    send_item(make_play(8'd0, 1'b0, 20'd0));

    hold_cycles = HOLD_CYCLES;
    while (sent < ITEM_COUNT) begin
      if ($urandom_range(9, 0) < 7) begin
        send_item(make_play(pick_track(), 1'($urandom_range(1, 0)), pick_len()));
        n = $urandom_range(30, 0);
        repeat (n) send_item(make_tick(SAMPLE_BITS'($urandom), $urandom_range(19, 0) != 0));
      end else if ($urandom_range(1, 0) == 0) begin
        send_item(make_play(TRACK_BITS'($urandom), 1'($urandom_range(1, 0)),
                            FADE_BITS'($urandom)));
      end else begin
        send_item(make_tick(SAMPLE_BITS'($urandom), 1'($urandom_range(1, 0))));
      end
      if (sent > ITEM_COUNT / 2 && sent < ITEM_COUNT / 2 + 20 && hold_cycles == 0) begin
        hold_cycles = HOLD_CYCLES / 2;
      end
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("track_switch_fade_ramp regression: pass");
    end else begin
      $display("track_switch_fade_ramp regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tsfr_pkg.sv
rtl/tsfr_div.sv
rtl/track_switch_fade_ramp.sv
test/track_switch_fade_ramp_scoreboard.sv
test/track_switch_fade_ramp_tb.sv
